>>> sv/iol_pkg.sv
// ============================================================================
// iol_pkg: shared definitions for the indexed ordered list
// Sizes, command and status codes, and the control bundle sent to the cells.
// ============================================================================
package iol_pkg;

    localparam int DEPTH     = 64;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int CMD_W     = 2;
    localparam int CNT_OUT_W = 7;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP     = 8;
    localparam int NGROUPS   = (DEPTH + GROUP - 1) / GROUP;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_INSERT = CMD_W'(0);
    localparam cmd_t CMD_REMOVE = CMD_W'(1);
    localparam cmd_t CMD_READ   = CMD_W'(2);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Per-cycle command to every cell of the row.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic                     rd;
        logic [IDX_W-1:0]         at;
        logic [IDX_W-1:0]         rd_pos;
        logic signed [DATA_W-1:0] value;
    } iol_ctl_t;

endpackage

>>> sv/iol_cell.sv
// ============================================================================
// iol_cell: one slot of the ordered list
// Holds one entry; takes the neighbor below on insert, above on remove.
// ============================================================================
module iol_cell
    import iol_pkg::*;
(
    input  logic                     clk,
    input  logic [IDX_W-1:0]         idx,
    input  iol_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data,
    output logic [DATA_W-1:0]        hit_data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.ins && idx == ctl.at)
        begin
            data_next = ctl.value;
        end
        else if (ctl.ins && idx > ctl.at)
        begin
            data_next = prev_data;
        end
        else if (ctl.rem && idx >= ctl.at)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // drive zero unless this slot is the one being read
    assign hit_data = (ctl.rd && idx == ctl.rd_pos) ? data_reg : '0;

endmodule

>>> sv/iol_group.sv
// ============================================================================
// iol_group: registered OR over one group of cell read taps
// First level of the read tree.
// ============================================================================
module iol_group
    import iol_pkg::*;
(
    input  logic                         clk,
    input  logic [GROUP-1:0][DATA_W-1:0] hit,
    output logic [DATA_W-1:0]            group_data
);

    logic [DATA_W-1:0] group_reg;
    logic [DATA_W-1:0] group_next;

    always_comb
    begin
        group_next = '0;
        for (int k = 0; k < GROUP; k++)
        begin
            group_next = group_next | hit[k];
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    assign group_data = group_reg;

endmodule

>>> sv/indexed_ordered_list.sv
// ============================================================================
// indexed_ordered_list: ordered list with insert, remove and read at an index
// A row of DEPTH cells shifts in the accept cycle; reads go through a two-level
// registered OR tree over the cells.
// ============================================================================
// Result path: an accepted item passes the stage-one registers, then the output registers.
// Throughput: one item per cycle; busy stays low, the cell row absorbs any
//   insert or remove in the accept cycle and the read tree is pipelined.
// Reset: rst_n clears the entry count and the result valid bits; entry contents
//   are not cleared and are only read after being written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_ordered_list
    import iol_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [CMD_W-1:0]            command,
    input  logic [POS_W-1:0]            position,
    input  logic signed [DATA_W-1:0]    value,
    output logic                        done,
    output logic [1:0]                  status,
    output logic signed [DATA_W-1:0]    read_value,
    output logic [CNT_OUT_W-1:0]        count
);

    // ------------------------------------------------------------------
    // Front end: decode the item against the current count
    // ------------------------------------------------------------------
    logic             accept;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CNT_W-1:0] last_idx;
    logic             full;
    logic             empty;
    iol_ctl_t         ctl;
    status_t          st;

    // the row shifts in the accept cycle, so no item is ever held off
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_c    = CMP_W'(position);
    assign cnt_c    = CMP_W'(count_reg);
    assign last_idx = count_reg - CNT_W'(1);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        ctl        = '0;
        ctl.value  = value;
        st         = ST_OK;
        count_next = count_reg;
        if (accept)
        begin
            unique case (command)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        // past the end means append at the rear
                        ctl.ins    = 1'b1;
                        ctl.at     = (pos_c >= cnt_c) ? count_reg[IDX_W-1:0]
                                                      : pos_c[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        // past the end means drop the rear entry
                        ctl.rem    = 1'b1;
                        ctl.at     = (pos_c >= cnt_c) ? last_idx[IDX_W-1:0]
                                                      : pos_c[IDX_W-1:0];
                        count_next = last_idx;
                    end
                end
                CMD_READ:
                begin
                    if (pos_c >= cnt_c)
                    begin
                        st = ST_RANGE;
                    end
                    else
                    begin
                        ctl.rd     = 1'b1;
                        ctl.rd_pos = pos_c[IDX_W-1:0];
                    end
                end
                default:
                begin
                    // unused command: answer ok, leave the list alone
                    st = ST_OK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell row: each cell sees its two neighbors
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0]     cell_data [DEPTH];
    logic [NGROUPS*GROUP-1:0][DATA_W-1:0] hit_w;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_w;
        logic signed [DATA_W-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_lo
            assign prev_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_hi
            assign next_w = cell_data[i+1];
        end

        iol_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .ctl       (ctl),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_data[i]),
            .hit_data  (hit_w[i])
        );
    end

    // pad the tree inputs past the last cell
    for (genvar p = DEPTH; p < NGROUPS * GROUP; p++)
    begin : g_pad
        assign hit_w[p] = '0;
    end

    // ------------------------------------------------------------------
    // Read tree, level one: registered OR per group of cells
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] group_data [NGROUPS];

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        iol_group u_group (
            .clk        (clk),
            .hit        (hit_w[g*GROUP +: GROUP]),
            .group_data (group_data[g])
        );
    end

    // ------------------------------------------------------------------
    // Result pipeline: stage one travels with the group registers,
    // stage two merges the groups and drives the result ports
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_valid_next;
    status_t           s1_status_reg;
    status_t           s1_status_next;
    logic [CNT_W-1:0]  s1_count_reg;
    logic [CNT_W-1:0]  s1_count_next;

    logic              done_reg;
    logic              done_next;
    status_t           status_reg;
    status_t           status_next;
    logic [CNT_W-1:0]  count_out_reg;
    logic [CNT_W-1:0]  count_out_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;

    always_comb
    begin
        s1_valid_next   = accept;
        s1_status_next  = st;
        s1_count_next   = count_next;
        done_next       = s1_valid_reg;
        status_next     = s1_status_reg;
        count_out_next  = s1_count_reg;
        read_value_next = '0;
        for (int k = 0; k < NGROUPS; k++)
        begin
            read_value_next = read_value_next | group_data[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            done_reg     <= done_next;
        end
    end

    // payload: hold no reset, qualified by the valid bits above
    always_ff @(posedge clk)
    begin
        s1_status_reg  <= s1_status_next;
        s1_count_reg   <= s1_count_next;
        status_reg     <= status_next;
        count_out_reg  <= count_out_next;
        read_value_reg <= read_value_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign count      = CNT_OUT_W'(count_out_reg);
    assign read_value = read_value_reg;

endmodule

>>> sv/iol_checker.sv
// ============================================================================
// iol_checker: port-level checks for the indexed ordered list
// Watches the command and result ports and flags broken result timing or
// inconsistent status, count and data.
// ============================================================================
module iol_checker
    import iol_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [1:0]               status,
    input logic signed [DATA_W-1:0] read_value,
    input logic [CNT_OUT_W-1:0]     count,
    input logic                     done
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> count == CNT_OUT_W'(DEPTH))
        else $error("full reported with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> count == '0)
        else $error("empty reported with nonzero count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_value == '0)
        else $error("nonzero read value on a failed item");

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .status     (status),
    .read_value (read_value),
    .count      (count),
    .done       (done)
);

>>> test/indexed_ordered_list_tb.sv
// ============================================================================
// indexed_ordered_list_tb: self-checking bench for the indexed ordered list
// Drives insert, remove and read requests through the start/busy handshake,
// predicts each result with a behavioral copy of the list, and checks every
// done strobe field by field against the oldest pending prediction.
// ============================================================================
module indexed_ordered_list_tb;

    import iol_pkg::*;

    // The package names only the three live commands; the fourth code is
    // legal on the port and must leave the list untouched.
    localparam cmd_t CMD_UNUSED = CMD_W'(3);

    // Quiet cycles (no item taken, no result seen) before the run is
    // declared hung. A correct run never goes longer than one gap of at most MAX_GAP
    // plus the result latency without activity.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_GAP      = 13;

    typedef struct {
        cmd_t                     cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int unsigned              gap;
    } list_request_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]     count;
    } list_result_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic [CMD_W-1:0]         command    = CMD_INSERT;
    logic [POS_W-1:0]         position   = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     count;

    indexed_ordered_list u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .position   (position),
        .value      (value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    list_request_t            pending_requests[$];
    list_result_t             expected_results[$];
    int                       total_items = 0;
    int                       n_taken     = 0;
    int                       n_errors    = 0;
    int                       quiet_cycles = 0;

    // Shadow list used by the predictor
    logic signed [DATA_W-1:0] list_mem [0:DEPTH-1];
    int                       list_len = 0;

    // Length the list will have once every queued item is applied; used
    // only to aim generated positions at interesting places.
    int                       gen_len = 0;

    // Driver bookkeeping
    list_request_t            next_req;
    logic                     staged   = 1'b0;
    int unsigned              gap_left = 0;

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the shadow list and return the result
    // ------------------------------------------------------------------------
    function automatic list_result_t list_apply(cmd_t cmd, logic [POS_W-1:0] pos,
                                                logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           at;
        int           i;
        r.status     = ST_OK;
        r.read_value = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Past the end means append at the rear
                    at = (int'(pos) >= list_len) ? list_len : int'(pos);
                    for (i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // Past the end means drop the rear entry
                    at = (int'(pos) >= list_len) ? list_len - 1 : int'(pos);
                    for (i = at; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_mem[pos];
            end
            default:
            begin
                // Unused code: no change, plain ok result
            end
        endcase
        r.count = CNT_OUT_W'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_request(cmd_t cmd, int pos, logic signed [DATA_W-1:0] val,
                               int unsigned gap);
        list_request_t q;
        q.cmd = cmd;
        q.pos = POS_W'(pos);
        q.val = val;
        q.gap = gap;
        pending_requests.push_back(q);
        total_items++;
        // Track the length the list will reach so positions can be aimed
        if (cmd == CMD_INSERT && gen_len < DEPTH)
            gen_len++;
        else if (cmd == CMD_REMOVE && gen_len > 0)
            gen_len--;
    endtask

    // Pick a position: mostly inside the live list (or just at its end),
    // sometimes anywhere in the field's range.
    function automatic int aim_position(cmd_t cmd);
        int hi;
        if ($urandom_range(0, 99) < 25 || gen_len == 0)
            return $urandom_range(0, (1 << POS_W) - 1);
        hi = (cmd == CMD_READ) ? gen_len - 1 : gen_len;
        if (hi > (1 << POS_W) - 1)
            hi = (1 << POS_W) - 1;
        return $urandom_range(0, hi);
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Directed opening, then phases that fill, drain, mix or mostly read
    task automatic build_stimulus();
        int          kind;
        int          len;
        int          idle_mode;
        int          w_ins;
        int          w_rem;
        int          w_rd;
        int          roll;
        int          n;
        int unsigned gap;
        cmd_t        cmd;

        // Empty list: out-of-range read, remove when empty, unused code
        add_request(CMD_READ,   0,  '0, 0);
        add_request(CMD_REMOVE, 0,  '0, 2);
        add_request(CMD_REMOVE, 63, '0, 0);
        add_request(CMD_UNUSED, 63, 32'h1234_5678, 0);
        // Inserts: beyond count, front, middle, rear, exactly at count
        add_request(CMD_INSERT, 63, {1'b1, {(DATA_W-1){1'b0}}}, 0);
        add_request(CMD_INSERT, 0,  {1'b0, {(DATA_W-1){1'b1}}}, 5);
        add_request(CMD_INSERT, 1,  '0, 0);
        add_request(CMD_INSERT, 63, '1, 0);
        add_request(CMD_INSERT, 3,  32'h5A5A_5A5A, 1);
        // Read every entry, then just past and far past the end
        for (n = 0; n < 5; n++)
            add_request(CMD_READ, n, '0, 0);
        add_request(CMD_READ, 5,  '0, 0);
        add_request(CMD_READ, 63, '0, 3);
        // Removes: beyond count, front, middle, then down to empty
        add_request(CMD_REMOVE, 63, '0, 0);
        add_request(CMD_REMOVE, 0,  '0, 0);
        add_request(CMD_REMOVE, 1,  '0, 0);
        add_request(CMD_READ,   0,  '0, 0);
        add_request(CMD_READ,   1,  '0, 0);
        add_request(CMD_REMOVE, 1,  '0, 0);
        add_request(CMD_REMOVE, 0,  '0, 0);
        add_request(CMD_READ,   0,  '0, 0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            // Open with an insert-heavy fill phase and a remove-heavy drain phase, then random phases
            if (n == 0)
                kind = 0;
            else if (n < 200)
                kind = 1;
            else
                kind = $urandom_range(0, 3);
            len       = (n < 200) ? 100 : $urandom_range(20, 80);
            idle_mode = $urandom_range(0, 2);
            case (kind)
                0:       begin w_ins = 75; w_rem = 8;  w_rd = 15; end
                1:       begin w_ins = 8;  w_rem = 75; w_rd = 15; end
                2:       begin w_ins = 35; w_rem = 30; w_rd = 33; end
                default: begin w_ins = 20; w_rem = 15; w_rd = 63; end
            endcase
            repeat (len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < w_ins)
                    cmd = CMD_INSERT;
                else if (roll < w_ins + w_rem)
                    cmd = CMD_REMOVE;
                else if (roll < w_ins + w_rem + w_rd)
                    cmd = CMD_READ;
                else
                    cmd = CMD_UNUSED;
                // Idle modes: none, occasional gaps, a gap drawn every item
                case (idle_mode)
                    0:       gap = 0;
                    1:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
                    default: gap = $urandom_range(0, MAX_GAP);
                endcase
                add_request(cmd, aim_position(cmd), draw_value(), gap);
                n++;
            end
        end
    endtask

    task automatic log_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present queued items, each after its own gap, hold while busy.
    // The prediction is taken at the edge that accepts the item, from the
    // port values that were on the bus before that edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            command  <= CMD_INSERT;
            position <= '0;
            value    <= '0;
            staged   = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(list_apply(command, position, value));
                n_taken <= n_taken + 1;
            end
            // Bus is free unless an item is being held off by busy
            if (!start || !busy)
            begin
                if (!staged && pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    staged   = 1'b1;
                    gap_left = next_req.gap;
                end
                if (staged && gap_left == 0)
                begin
                    start    <= 1'b1;
                    command  <= next_req.cmd;
                    position <= next_req.pos;
                    value    <= next_req.val;
                    staged   = 1'b0;
                end
                else
                begin
                    // Drop start for this cycle and, if an item is staged, count down its gap
                    start <= 1'b0;
                    if (staged)
                        gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done strobe is one result; match it against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                log_mismatch("unexpected result, count", count, -1);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    log_mismatch("status", status, want.status);
                if (read_value !== want.read_value)
                    log_mismatch("read_value", read_value, want.read_value);
                if (count !== want.count)
                    log_mismatch("count", count, want.count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("indexed_ordered_list_tb: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the item list, release reset, drain, report
    // ------------------------------------------------------------------------
    initial
    begin
        build_stimulus();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // Hold until every item is taken and every result has come back
        while (n_taken < total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Let any stray strobe show up before judging
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("indexed_ordered_list_tb: PASS");
        else
            $display("indexed_ordered_list_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/iol_pkg.sv
sv/iol_cell.sv
sv/iol_group.sv
sv/indexed_ordered_list.sv
sv/iol_checker.sv
test/indexed_ordered_list_tb.sv
